// File: hw/rtl/orfsm_pkg.sv
// ----------------------------------------------------------------------------
// orfsm_pkg
// Types, constants and helper functions for the ORF scanner with mass unit.
// ----------------------------------------------------------------------------
`default_nettype none

package orfsm_pkg;

  localparam int unsigned POS_W   = 21;
  localparam int unsigned IDX_W   = 20;
  localparam int unsigned BP_W    = 22;
  localparam int unsigned MASS_W  = 41;
  localparam int unsigned RMASS_W = 21;
  localparam int unsigned FRAME_W = 3;
  localparam int unsigned RES_W   = 8;
  localparam int unsigned CFG_W   = 21;
  localparam int unsigned CFGI_W  = 2;

  localparam logic [POS_W-1:0]   MAX_SEQ_LEN = POS_W'(1048576);
  localparam logic [MASS_W-1:0]  WATER_MASS  = MASS_W'(180152);
  localparam logic [RES_W-1:0]   RES_START   = 8'h4D;  // 'M'
  localparam logic [RES_W-1:0]   RES_STOP    = 8'h2A;  // '*'
  localparam logic [FRAME_W-1:0] FIRST_REV_FRAME = 3'd3;

  localparam logic [CFGI_W-1:0] REG_MIN_ORF_LENGTH  = 2'd0;
  localparam logic [CFGI_W-1:0] REG_FRAME_SELECT    = 2'd1;
  localparam logic [CFGI_W-1:0] REG_SEQUENCE_LENGTH = 2'd2;

  typedef struct packed {
    logic              in_orf;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  cur_len;
    logic [POS_W-1:0]  start;
    logic [MASS_W-1:0] mass;
    logic [IDX_W-1:0]  count;
  } scan_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  count;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  stop;
    logic [POS_W-1:0]  len;
    logic [MASS_W-1:0] mass;
    logic              by_end;
  } emit_rec_t;

  typedef struct packed {
    logic [IDX_W-1:0]  orf_index;
    logic [POS_W-1:0]  begin_aa;
    logic [BP_W-1:0]   begin_bp;
    logic [POS_W-1:0]  end_aa;
    logic [BP_W-1:0]   end_bp;
    logic [POS_W-1:0]  orf_length;
    logic [MASS_W-1:0] mol_weight;
    logic              closed_by_end;
  } orf_word_t;

  // residue mass in 0.0001 Da, zero for anything not in the table
  function automatic logic [RMASS_W-1:0] mass_of(input logic [RES_W-1:0] r);
    logic [RMASS_W-1:0] m;
    case (r)
      8'h41:   m = RMASS_W'(710800);   // A
      8'h43:   m = RMASS_W'(1031400);  // C
      8'h44:   m = RMASS_W'(1150900);  // D
      8'h45:   m = RMASS_W'(1291200);  // E
      8'h46:   m = RMASS_W'(1471800);  // F
      8'h47:   m = RMASS_W'(570600);   // G
      8'h48:   m = RMASS_W'(1371500);  // H
      8'h49:   m = RMASS_W'(1131700);  // I
      8'h4B:   m = RMASS_W'(1281800);  // K
      8'h4C:   m = RMASS_W'(1131700);  // L
      8'h4D:   m = RMASS_W'(1312100);  // M
      8'h4E:   m = RMASS_W'(1141100);  // N
      8'h50:   m = RMASS_W'(971200);   // P
      8'h51:   m = RMASS_W'(1281400);  // Q
      8'h52:   m = RMASS_W'(1562000);  // R
      8'h53:   m = RMASS_W'(870800);   // S
      8'h54:   m = RMASS_W'(1011100);  // T
      8'h56:   m = RMASS_W'(991400);   // V
      8'h57:   m = RMASS_W'(1862100);  // W
      8'h58:   m = RMASS_W'(1188900);  // X
      8'h59:   m = RMASS_W'(1631800);  // Y
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v >= MAX_SEQ_LEN) ? MAX_SEQ_LEN : v + POS_W'(1);
  endfunction

  function automatic logic [MASS_W-1:0] sat_add(input logic [MASS_W-1:0] a,
                                                input logic [RMASS_W-1:0] m);
    logic [MASS_W:0] s;
    s = {1'b0, a} + (MASS_W+1)'(m);
    return s[MASS_W] ? {MASS_W{1'b1}} : s[MASS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/orfsm_in_if.sv
// ----------------------------------------------------------------------------
// orfsm_in_if
// Residue stream channel: valid/ready with one letter and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface orfsm_in_if import orfsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] residue;
  logic             last;

  modport source (output valid, output residue, output last, input ready);
  modport sink   (input valid, input residue, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/orfsm_out_if.sv
// ----------------------------------------------------------------------------
// orfsm_out_if
// ORF result channel: valid/ready with one ORF record.
// ----------------------------------------------------------------------------
`default_nettype none

interface orfsm_out_if import orfsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  orf_index;
  logic [POS_W-1:0]  begin_aa;
  logic [BP_W-1:0]   begin_bp;
  logic [POS_W-1:0]  end_aa;
  logic [BP_W-1:0]   end_bp;
  logic [POS_W-1:0]  orf_length;
  logic [MASS_W-1:0] mol_weight;
  logic              closed_by_end;

  modport source (output valid, output orf_index, output begin_aa, output begin_bp,
                  output end_aa, output end_bp, output orf_length, output mol_weight,
                  output closed_by_end, input ready);
  modport sink   (input valid, input orf_index, input begin_aa, input begin_bp,
                  input end_aa, input end_bp, input orf_length, input mol_weight,
                  input closed_by_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/orf_scanner_with_mass_unit.sv
// ----------------------------------------------------------------------------
// orf_scanner_with_mass_unit
// Scans one translated reading frame and reports each ORF that reaches the
// minimum length with its offsets, length and molecular weight.
//
//   channel    dir  handshake     word
//   residues   in   valid/ready   residue, last
//   orfs       out  valid/ready   orf_index .. closed_by_end
//   wr_*       in   wr_en         wr_index, wr_data (no read-back)
//
// One residue per cycle while no result is held. The residue is registered
// in the input register and the result in the output register. The scan
// state register and its combinational update logic form the only loop.
// A held result stalls the scan; the input register can still take one
// residue, then residues.ready stays low until the result is read.
// Synchronous reset clears scan state, configuration and valid registers.
// ----------------------------------------------------------------------------
`default_nettype none

module orf_scanner_with_mass_unit import orfsm_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                wr_en,
  input  wire [CFGI_W-1:0]   wr_index,
  input  wire [CFG_W-1:0]    wr_data,
  orfsm_in_if.sink           residues,
  orfsm_out_if.source        orfs
);

  logic [POS_W-1:0]   min_orf_length;
  logic [FRAME_W-1:0] frame_select;
  logic [POS_W-1:0]   sequence_length;

  logic               in_valid;
  logic [RES_W-1:0]   in_residue;
  logic               in_last;

  scan_state_t        state;
  scan_state_t        state_next;
  logic               emit;
  emit_rec_t          rec;
  orf_word_t          word_next;

  logic               out_valid;
  orf_word_t          out_word;
  logic               adv;

  assign adv            = in_valid && (!out_valid || orfs.ready);
  assign residues.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_orf_length  <= '0;
      frame_select    <= '0;
      sequence_length <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN_ORF_LENGTH:  min_orf_length  <= wr_data[POS_W-1:0];
        REG_FRAME_SELECT:    frame_select    <= wr_data[FRAME_W-1:0];
        REG_SEQUENCE_LENGTH: sequence_length <= wr_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (residues.valid && residues.ready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (residues.valid && residues.ready) begin
      in_residue <= residues.residue;
      in_last    <= residues.last;
    end
  end

  orfsm_core u_core (
    .cur     (state),
    .residue (in_residue),
    .last    (in_last),
    .min_len (min_orf_length),
    .nxt     (state_next),
    .emit    (emit),
    .rec     (rec)
  );

  orfsm_offsets u_offsets (
    .rec     (rec),
    .frame   (frame_select),
    .seq_len (sequence_length),
    .word    (word_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      state     <= state_next;
      out_valid <= emit;
    end else if (orfs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_word <= word_next;
    end
  end

  assign orfs.valid         = out_valid;
  assign orfs.orf_index     = out_word.orf_index;
  assign orfs.begin_aa      = out_word.begin_aa;
  assign orfs.begin_bp      = out_word.begin_bp;
  assign orfs.end_aa        = out_word.end_aa;
  assign orfs.end_bp        = out_word.end_bp;
  assign orfs.orf_length    = out_word.orf_length;
  assign orfs.mol_weight    = out_word.mol_weight;
  assign orfs.closed_by_end = out_word.closed_by_end;

endmodule

`default_nettype wire

// File: hw/rtl/orfsm_core.sv
// ----------------------------------------------------------------------------
// orfsm_core
// Next-state logic of the scanner: opens, extends and closes an ORF for one
// residue and flags an emission with its raw record.
// ----------------------------------------------------------------------------
`default_nettype none

module orfsm_core import orfsm_pkg::*; (
  input  wire scan_state_t      cur,
  input  wire [RES_W-1:0]       residue,
  input  wire                   last,
  input  wire [POS_W-1:0]       min_len,
  output scan_state_t           nxt,
  output logic                  emit,
  output emit_rec_t             rec
);

  logic [RMASS_W-1:0] m;
  logic [POS_W-1:0]   pos_next;
  logic [POS_W-1:0]   base_len;
  logic [MASS_W-1:0]  base_mass;
  logic               append;

  assign m        = mass_of(residue);
  assign pos_next = sat_inc(cur.position);

  always_comb begin
    nxt        = cur;
    emit       = 1'b0;
    append     = 1'b0;
    base_len   = cur.cur_len;
    base_mass  = cur.mass;
    rec.count  = cur.count;
    rec.stop   = cur.position;
    rec.len    = cur.cur_len;
    rec.mass   = cur.mass;
    rec.by_end = 1'b0;

    if (residue == RES_START) begin
      nxt.in_orf = 1'b1;
      if (!cur.in_orf) begin
        nxt.start = cur.position;
        base_len  = '0;
        base_mass = WATER_MASS;
      end
      append = 1'b1;
    end else if (residue == RES_STOP) begin
      if (cur.in_orf) begin
        nxt.in_orf  = 1'b0;
        emit        = (cur.cur_len >= min_len);
        nxt.cur_len = '0;
        nxt.mass    = '0;
      end
    end else if (cur.in_orf) begin
      append = 1'b1;
    end

    if (append) begin
      nxt.cur_len = sat_inc(base_len);
      nxt.mass    = sat_add(base_mass, m);
    end
    nxt.position = pos_next;
    rec.start    = nxt.start;

    if (emit) begin
      nxt.count = cur.count + IDX_W'(1);
    end

    if (last) begin
      if (nxt.in_orf && (nxt.cur_len >= min_len)) begin
        emit       = 1'b1;
        rec.by_end = 1'b1;
        rec.stop   = pos_next;
        rec.len    = nxt.cur_len;
        rec.mass   = nxt.mass;
      end
      nxt = '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/orfsm_offsets.sv
// ----------------------------------------------------------------------------
// orfsm_offsets
// Turns a raw ORF record into amino-acid and base-pair offsets for the
// selected forward or reverse frame.
// ----------------------------------------------------------------------------
`default_nettype none

module orfsm_offsets import orfsm_pkg::*; (
  input  wire emit_rec_t        rec,
  input  wire [FRAME_W-1:0]     frame,
  input  wire [POS_W-1:0]       seq_len,
  output orf_word_t             word
);

  logic [POS_W-1:0] l_sat;
  logic [POS_W-1:0] b_aa;
  logic [POS_W-1:0] e_aa;
  logic [BP_W:0]    b_bp;
  logic [BP_W:0]    e_bp;
  logic             fwd;

  assign fwd   = (frame < FIRST_REV_FRAME);
  assign l_sat = (seq_len > MAX_SEQ_LEN) ? MAX_SEQ_LEN : seq_len;

  always_comb begin
    if (fwd) begin
      b_aa = rec.start;
      e_aa = rec.stop;
    end else begin
      b_aa = (l_sat > rec.start) ? l_sat - rec.start : '0;
      e_aa = (l_sat > rec.stop)  ? l_sat - rec.stop  : '0;
    end
    // 3x as x + 2x
    b_bp = (BP_W+1)'(b_aa) + (BP_W+1)'({b_aa, 1'b0});
    e_bp = (BP_W+1)'(e_aa) + (BP_W+1)'({e_aa, 1'b0}) + (BP_W+1)'(frame);
    if (fwd) begin
      b_bp = b_bp + (BP_W+1)'(frame) + (BP_W+1)'(1);
    end
  end

  assign word.orf_index     = rec.count;
  assign word.begin_aa      = b_aa;
  assign word.begin_bp      = b_bp[BP_W-1:0];
  assign word.end_aa        = e_aa;
  assign word.end_bp        = e_bp[BP_W-1:0];
  assign word.orf_length    = rec.len;
  assign word.mol_weight    = rec.mass;
  assign word.closed_by_end = rec.by_end;

endmodule

`default_nettype wire
